>>> rtl/cosine_taylor_series_macros.svh
// ---------------------------------------------------------------------------
// cosine_taylor_series_macros
// assertion macros shared by the cosine series checker
// ---------------------------------------------------------------------------
`ifndef COSINE_TAYLOR_SERIES_MACROS_SVH
`define COSINE_TAYLOR_SERIES_MACROS_SVH

// same-cycle implication
`define CTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/cts_pkg.sv
// ---------------------------------------------------------------------------
// cts_pkg
// shared constants, types and command structs of the cosine series block
// ---------------------------------------------------------------------------
package cts_pkg;

   localparam int MAX_TERMS_DEF = 16;
   localparam int FRAC_BITS_DEF = 30;

   localparam int ANGLE_W = 17;
   localparam int COS_W   = 32;
   localparam int TERMS_W = 5;
   localparam int THR_W   = 31;

   // pi in Q60 and the per-lsb radian factor pi / 46080 in Q60
   localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
   localparam logic [63:0] K_Q60  = (PI_Q60 + 64'd23040) / 64'd46080;
   localparam int          K_W    = 47;
   localparam logic [K_W-1:0] K_RAD = K_Q60[K_W-1:0];

   localparam logic signed [COS_W-1:0] COS_ONE = 32'sh4000_0000;
   localparam logic [TERMS_W-1:0]      TERMS_SAT = '1;

   typedef enum logic [1:0] {
      OP_ANGLE,
      OP_SQUARE,
      OP_TERM,
      OP_RECIP
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_START,
      ST_MUL_WAIT,
      ST_CHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic   load_in;
      logic   mul_start;
      logic   capture;
      logic   step;
      logic   load_out;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic more;
   } status_type;

endpackage

>>> rtl/cts_mul.sv
// ---------------------------------------------------------------------------
// cts_mul
// shared multi-cycle multiplier, one 32x32 partial product per cycle
// ---------------------------------------------------------------------------
module cts_mul #(
   parameter int MOP_W = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MOP_W-1:0]   opa,
   input  logic [MOP_W-1:0]   opb,
   output logic               done,
   output logic [2*MOP_W-1:0] prod
);

   localparam int NC   = MOP_W / 32;
   localparam int IW   = (NC > 1) ? $clog2(NC) : 1;
   localparam int PR_W = 2 * MOP_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [IW-1:0]     i_ff, i_in;
   logic [IW-1:0]     j_ff, j_in;
   logic [PR_W-1:0]   acc_ff, acc_in;
   logic [63:0]       pp;
   logic [IW:0]       ij_sum;
   logic [IW+5:0]     sh_amt;
   logic [PR_W-1:0]   pp_sh;
   logic              last;

   assign pp     = opa[{i_ff, 5'b0} +: 32] * opb[{j_ff, 5'b0} +: 32];
   assign ij_sum = (IW+1)'(i_ff) + (IW+1)'(j_ff);
   assign sh_amt = {ij_sum, 5'b0};
   assign pp_sh  = PR_W'(pp) << sh_amt;
   assign last   = (i_ff == IW'(NC - 1)) && (j_ff == IW'(NC - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      i_in    = i_ff;
      j_in    = j_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         i_in    = '0;
         j_in    = '0;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + pp_sh;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (j_ff == IW'(NC - 1)) begin
            j_in = '0;
            i_in = i_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
         j_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

>>> rtl/cts_datapath.sv
// ---------------------------------------------------------------------------
// cts_datapath
// angle scaling, series term recurrence, running sum and result register
// ---------------------------------------------------------------------------
module cts_datapath #(
   parameter int MAX_TERMS = cts_pkg::MAX_TERMS_DEF,
   parameter int FRAC_BITS = cts_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cts_pkg::cmd_type                      cmd,
   output cts_pkg::status_type                   status,
   input  logic signed [cts_pkg::ANGLE_W-1:0]    req_angle_deg,
   input  logic                                  csr_wr_en,
   input  logic [cts_pkg::THR_W-1:0]             csr_wr_data,
   output logic signed [cts_pkg::COS_W-1:0]      rsp_cosine,
   output logic [cts_pkg::TERMS_W-1:0]           rsp_terms_used
);

   localparam int ANGLE_W = cts_pkg::ANGLE_W;
   localparam int COS_W   = cts_pkg::COS_W;
   localparam int TERMS_W = cts_pkg::TERMS_W;
   localparam int THR_W   = cts_pkg::THR_W;
   localparam int K_W     = cts_pkg::K_W;

   localparam int X_W    = FRAC_BITS + 3;
   localparam int X2_W   = FRAC_BITS + 5;
   localparam int TERM_W = FRAC_BITS + 5;
   localparam int NUM_W  = FRAC_BITS + 9;
   localparam int SUM_W  = FRAC_BITS + 7;
   localparam int Q_W    = SUM_W + 30;

   localparam int D_MAX  = 2 * MAX_TERMS * (2 * MAX_TERMS - 1);
   localparam int D_W    = $clog2(D_MAX + 1);
   localparam int SH     = NUM_W + D_W;
   localparam int RCP_W  = SH;
   localparam int CNT_W  = $clog2(MAX_TERMS + 1);
   localparam int IDX_W  = $clog2(MAX_TERMS);
   localparam int NW_W   = CNT_W + 5;

   localparam int OPND_W = (SH > K_W) ? SH : K_W;
   localparam int NC     = (OPND_W + 31) / 32;
   localparam int MOP_W  = NC * 32;
   localparam int PR_W   = 2 * MOP_W;

   // reciprocal and half-divisor tables for d = 2n(2n-1)
   logic [RCP_W-1:0] rcp_tab  [MAX_TERMS];
   logic [D_W-1:0]   half_tab [MAX_TERMS];

   for (genvar g = 0; g < MAX_TERMS; g++) begin : g_tab
      localparam logic [SH:0] POW = {1'b1, {SH{1'b0}}};
      localparam logic [SH:0] DIV = (SH+1)'(2 * (g + 1) * (2 * (g + 1) - 1));
      localparam logic [SH:0] RCP = (POW + DIV - 1'b1) / DIV;
      assign rcp_tab[g]  = RCP[RCP_W-1:0];
      assign half_tab[g] = D_W'((g + 1) * (2 * (g + 1) - 1));
   end

   logic [THR_W-1:0]        csr_ff;
   logic [ANGLE_W-1:0]      mag_ff, mag_in;
   logic [X_W-1:0]          x_ff, x_in;
   logic [X2_W-1:0]         x2_ff, x2_in;
   logic [TERM_W-1:0]       term_ff, term_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        n_ff;
   logic signed [COS_W-1:0] rsp_cosine_ff;
   logic [TERMS_W-1:0]      rsp_terms_ff;

   logic [ANGLE_W-1:0]      neg_angle;
   logic [CNT_W-1:0]        n_dec;
   logic [IDX_W-1:0]        idx;
   logic [MOP_W-1:0]        opa, opb;
   logic [PR_W-1:0]         prod;
   logic                    mul_done;
   logic [PR_W-1:0]         prod_rnd_ang, prod_rnd_f;
   logic [SUM_W-1:0]        q_ext;
   logic [TERM_W-1:0]       thr_scaled;

   logic                    neg;
   logic [SUM_W-1:0]        smag;
   logic [Q_W-1:0]          q30_w;
   logic [COS_W-2:0]        q30_sat;
   logic [COS_W-1:0]        cos_mag, cos_val;
   logic [NW_W-1:0]         n_wide;
   logic [TERMS_W-1:0]      terms_val;

   // angle magnitude
   assign neg_angle = -$unsigned(req_angle_deg);
   assign mag_in    = req_angle_deg[ANGLE_W-1] ? neg_angle : $unsigned(req_angle_deg);

   assign n_dec = n_ff - 1'b1;
   assign idx   = n_dec[IDX_W-1:0];

   always_comb begin
      unique case (cmd.op)
         cts_pkg::OP_ANGLE: begin
            opa = MOP_W'(mag_ff);
            opb = MOP_W'(cts_pkg::K_RAD);
         end
         cts_pkg::OP_SQUARE: begin
            opa = MOP_W'(x_ff);
            opb = MOP_W'(x_ff);
         end
         cts_pkg::OP_TERM: begin
            opa = MOP_W'(term_ff);
            opb = MOP_W'(x2_ff);
         end
         cts_pkg::OP_RECIP: begin
            opa = MOP_W'(num_ff);
            opb = MOP_W'(rcp_tab[idx]);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   cts_mul #(
      .MOP_W (MOP_W)
   ) u_cts_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .opa   (opa),
      .opb   (opb),
      .done  (mul_done),
      .prod  (prod)
   );

   // rounding of the product back to the working format
   assign prod_rnd_ang = prod + (PR_W'(1) << (59 - FRAC_BITS));
   assign prod_rnd_f   = prod + (PR_W'(1) << (FRAC_BITS - 1));

   assign x_in    = prod_rnd_ang[60 - FRAC_BITS +: X_W];
   assign x2_in   = prod_rnd_f[FRAC_BITS +: X2_W];
   assign num_in  = prod_rnd_f[FRAC_BITS +: NUM_W] + NUM_W'(half_tab[idx]);
   assign term_in = prod[SH +: TERM_W];
   assign q_ext   = SUM_W'(term_in);
   assign sum_in  = n_ff[0] ? (sum_ff - $signed(q_ext)) : (sum_ff + $signed(q_ext));

   // threshold moved into the working format
   if (FRAC_BITS >= 30) begin : g_thr_up
      assign thr_scaled = TERM_W'(csr_ff) << (FRAC_BITS - 30);
   end else begin : g_thr_dn
      logic [THR_W:0] thr_rnd;
      assign thr_rnd    = {1'b0, csr_ff} + ((THR_W+1)'(1) << (29 - FRAC_BITS));
      assign thr_scaled = TERM_W'(thr_rnd >> (30 - FRAC_BITS));
   end

   assign status.mul_done = mul_done;
   assign status.more     = (term_ff > thr_scaled) && (n_ff < CNT_W'(MAX_TERMS));

   // final conversion to Q2.30 (rounded when FRAC_BITS > 30) and saturation
   assign neg  = sum_ff[SUM_W-1];
   assign smag = neg ? $unsigned(-sum_ff) : $unsigned(sum_ff);

   if (FRAC_BITS > 30) begin : g_q30_dn
      assign q30_w = (Q_W'(smag) + (Q_W'(1) << (FRAC_BITS - 31))) >> (FRAC_BITS - 30);
   end else if (FRAC_BITS == 30) begin : g_q30_eq
      assign q30_w = Q_W'(smag);
   end else begin : g_q30_up
      assign q30_w = Q_W'(smag) << (30 - FRAC_BITS);
   end

   assign q30_sat = (q30_w > Q_W'(cts_pkg::COS_ONE)) ? (COS_W-1)'(cts_pkg::COS_ONE)
                                                     : q30_w[COS_W-2:0];
   assign cos_mag = COS_W'(q30_sat);
   assign cos_val = neg ? -cos_mag : cos_mag;

   assign n_wide    = NW_W'(n_ff);
   assign terms_val = (n_wide > NW_W'(cts_pkg::TERMS_SAT)) ? cts_pkg::TERMS_SAT
                                                           : n_wide[TERMS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_wr_en) begin
         csr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         mag_ff  <= mag_in;
         term_ff <= TERM_W'(1) << FRAC_BITS;
         sum_ff  <= $signed(SUM_W'(1) << FRAC_BITS);
         n_ff    <= '0;
      end
      if (cmd.step) begin
         n_ff <= n_ff + 1'b1;
      end
      if (cmd.capture) begin
         unique case (cmd.op)
            cts_pkg::OP_ANGLE:  x_ff   <= x_in;
            cts_pkg::OP_SQUARE: x2_ff  <= x2_in;
            cts_pkg::OP_TERM:   num_ff <= num_in;
            cts_pkg::OP_RECIP: begin
               term_ff <= term_in;
               sum_ff  <= sum_in;
            end
            default: ;
         endcase
      end
      if (cmd.load_out) begin
         rsp_cosine_ff <= $signed(cos_val);
         rsp_terms_ff  <= terms_val;
      end
   end

   assign rsp_cosine     = rsp_cosine_ff;
   assign rsp_terms_used = rsp_terms_ff;

endmodule

>>> rtl/cts_ctrl.sv
// ---------------------------------------------------------------------------
// cts_ctrl
// sequencer for the series evaluation and the output handshake
// ---------------------------------------------------------------------------
module cts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  cts_pkg::status_type status,
   output cts_pkg::cmd_type    cmd
);

   cts_pkg::state_type state_ff, state_in;
   cts_pkg::op_type    op_ff, op_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cmd           = '0;
      cmd.op        = op_ff;
      req_ready     = 1'b0;
      unique case (state_ff)
         cts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               op_in       = cts_pkg::OP_ANGLE;
               state_in    = cts_pkg::ST_MUL_START;
            end
         end
         cts_pkg::ST_MUL_START: begin
            cmd.mul_start = 1'b1;
            state_in      = cts_pkg::ST_MUL_WAIT;
         end
         cts_pkg::ST_MUL_WAIT: begin
            if (status.mul_done) begin
               cmd.capture = 1'b1;
               unique case (op_ff)
                  cts_pkg::OP_ANGLE: begin
                     op_in    = cts_pkg::OP_SQUARE;
                     state_in = cts_pkg::ST_MUL_START;
                  end
                  cts_pkg::OP_TERM: begin
                     op_in    = cts_pkg::OP_RECIP;
                     state_in = cts_pkg::ST_MUL_START;
                  end
                  default: state_in = cts_pkg::ST_CHECK;
               endcase
            end
         end
         cts_pkg::ST_CHECK: begin
            if (status.more) begin
               cmd.step = 1'b1;
               op_in    = cts_pkg::OP_TERM;
               state_in = cts_pkg::ST_MUL_START;
            end else begin
               state_in = cts_pkg::ST_FINISH;
            end
         end
         cts_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = cts_pkg::ST_IDLE;
            end
         end
         default: state_in = cts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cts_pkg::ST_IDLE;
         op_ff        <= cts_pkg::OP_ANGLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/cosine_taylor_series.sv
// ---------------------------------------------------------------------------
// cosine_taylor_series
// cosine of an angle in degrees by a fixed-point Taylor series
// ---------------------------------------------------------------------------
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_angle_deg (s17, deg * 256)
// rsp       out        rsp_valid / rsp_ready  rsp_cosine (s32 Q2.30), rsp_terms_used
// csr       in         csr_wr_en              csr_wr_data (stop threshold, Q1.30)
//
// one transaction at a time; the result register is loaded once the shared
// multiplier has run the angle setup (angle and square products) and then
// two products per series term, each built from 32x32 partial products
// the next request is taken as soon as the result sits in the output register
// a stalled response holds the sequencer in its last state until the slot frees
// synchronous active-high reset; threshold resets to zero
// ---------------------------------------------------------------------------
module cosine_taylor_series #(
   parameter int MAX_TERMS = cts_pkg::MAX_TERMS_DEF,
   parameter int FRAC_BITS = cts_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [cts_pkg::ANGLE_W-1:0] req_angle_deg,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [cts_pkg::COS_W-1:0]   rsp_cosine,
   output logic [cts_pkg::TERMS_W-1:0]        rsp_terms_used,
   input  logic                               csr_wr_en,
   input  logic [cts_pkg::THR_W-1:0]          csr_wr_data
);

   cts_pkg::cmd_type    cmd;
   cts_pkg::status_type status;

   cts_ctrl u_cts_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cts_datapath #(
      .MAX_TERMS (MAX_TERMS),
      .FRAC_BITS (FRAC_BITS)
   ) u_cts_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_angle_deg  (req_angle_deg),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_cosine     (rsp_cosine),
      .rsp_terms_used (rsp_terms_used)
   );

endmodule

>>> rtl/cts_checker.sv
// ---------------------------------------------------------------------------
// cts_checker
// port-level assertions for the cosine series block
// ---------------------------------------------------------------------------
`include "cosine_taylor_series_macros.svh"

module cts_checker #(
   parameter int MAX_TERMS = cts_pkg::MAX_TERMS_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [cts_pkg::COS_W-1:0]   rsp_cosine,
   input logic [cts_pkg::TERMS_W-1:0]        rsp_terms_used
);

   localparam logic [cts_pkg::TERMS_W-1:0] TERMS_LIMIT =
      (MAX_TERMS > 31) ? cts_pkg::TERMS_W'(31) : cts_pkg::TERMS_W'(MAX_TERMS);

   logic                                       req_fire;
   logic                                       rsp_stall;
   logic [cts_pkg::COS_W+cts_pkg::TERMS_W-1:0] rsp_payload;
   logic                                       cos_in_range;
   logic                                       no_terms;
   logic                                       cos_is_one;

   assign req_fire     = req_valid && req_ready;
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_payload  = {rsp_cosine, rsp_terms_used};
   assign cos_in_range = (rsp_cosine <= cts_pkg::COS_ONE) && (rsp_cosine >= -cts_pkg::COS_ONE);
   assign no_terms     = rsp_valid && (rsp_terms_used == '0);
   assign cos_is_one   = (rsp_cosine == cts_pkg::COS_ONE);

   `CTS_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "response not held")
   `CTS_ASSERT_NOW(a_cos_range, rsp_valid, cos_in_range, "cosine outside plus or minus one")
   `CTS_ASSERT_NOW(a_terms_bound, rsp_valid, rsp_terms_used <= TERMS_LIMIT, "term count too high")
   `CTS_ASSERT_NOW(a_no_terms_one, no_terms, cos_is_one, "no terms but result not one")
   `CTS_ASSERT_NEXT(a_busy_after_req, req_fire, !req_ready, "ready right after request")

endmodule

bind cosine_taylor_series cts_checker #(
   .MAX_TERMS (MAX_TERMS)
) u_cts_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_cosine     (rsp_cosine),
   .rsp_terms_used (rsp_terms_used)
);
